@@ rtl/core/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, operation and status codes for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int PRE_W = 34;
	localparam int QB    = 18;
	localparam int DW    = 33;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_CONJ = 3'd4
	} op_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_OVF     = 2'd2;

	typedef struct packed {
		logic                    is_div;
		logic                    divz;
		logic signed [PRE_W-1:0] pre_r;
		logic signed [PRE_W-1:0] pre_i;
	} side_t;

	typedef struct packed {
		logic        ovf;
		logic [15:0] val;
	} sat_t;

	function automatic sat_t sat16(input logic signed [PRE_W-1:0] v);
		sat_t r;
		if (v > $signed(PRE_W'(32767))) begin
			r.ovf = 1'b1;
			r.val = 16'h7fff;
		end else if (v < -$signed(PRE_W'(32768))) begin
			r.ovf = 1'b1;
			r.val = 16'h8000;
		end else begin
			r.ovf = 1'b0;
			r.val = v[15:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/cau_front.sv @@
// ----------------------------------------------------------------------------
// cau_front
// Product stage and combine stage: forms add/sub/mul/conj results and the
// divider operands.
// ----------------------------------------------------------------------------
module cau_front #(
	parameter int FRAC_BITS = 8,
	parameter int NW        = FRAC_BITS + 34
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [2:0]                   action,
	input  logic signed [15:0]           x_real,
	input  logic signed [15:0]           x_imag,
	input  logic signed [15:0]           y_real,
	input  logic signed [15:0]           y_imag,
	output logic                         vld_s2,
	output cau_pkg::side_t               side_s2,
	output logic                         neg_r_s2,
	output logic                         neg_i_s2,
	output logic [NW-1:0]                num_r_s2,
	output logic [NW-1:0]                num_i_s2,
	output logic [cau_pkg::DW-1:0]       den_s2
);
	import cau_pkg::*;

	localparam logic signed [PRE_W-1:0] HALF = (PRE_W'(1) <<< FRAC_BITS) >>> 1;

	logic               vld_s1;
	logic [2:0]         act_s1;
	logic signed [15:0] xr_s1, xi_s1, yr_s1, yi_s1;
	logic signed [31:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_yr_s1, p_yi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		act_s1  <= action;
		xr_s1   <= x_real;
		xi_s1   <= x_imag;
		yr_s1   <= y_real;
		yi_s1   <= y_imag;
		p_rr_s1 <= x_real * y_real;
		p_ii_s1 <= x_imag * y_imag;
		p_ri_s1 <= x_real * y_imag;
		p_ir_s1 <= x_imag * y_real;
		p_yr_s1 <= y_real * y_real;
		p_yi_s1 <= y_imag * y_imag;
	end

	logic signed [PRE_W-1:0] mr, mi, nr, ni;
	logic [31:0]             d;
	logic [31:0]             mag_r, mag_i;
	side_t                   sd;

	always_comb begin
		mr    = PRE_W'(p_rr_s1) - PRE_W'(p_ii_s1) + HALF;
		mi    = PRE_W'(p_ri_s1) + PRE_W'(p_ir_s1) + HALF;
		nr    = PRE_W'(p_rr_s1) + PRE_W'(p_ii_s1);
		ni    = PRE_W'(p_ir_s1) - PRE_W'(p_ri_s1);
		d     = p_yr_s1[31:0] + p_yi_s1[31:0];
		mag_r = nr[PRE_W-1] ? 32'(-nr) : nr[31:0];
		mag_i = ni[PRE_W-1] ? 32'(-ni) : ni[31:0];
		sd.is_div = 1'b0;
		sd.divz   = (d == 32'd0);
		sd.pre_r  = '0;
		sd.pre_i  = '0;
		unique case (act_s1)
			OP_ADD: begin
				sd.pre_r = PRE_W'(xr_s1) + PRE_W'(yr_s1);
				sd.pre_i = PRE_W'(xi_s1) + PRE_W'(yi_s1);
			end
			OP_SUB: begin
				sd.pre_r = PRE_W'(xr_s1) - PRE_W'(yr_s1);
				sd.pre_i = PRE_W'(xi_s1) - PRE_W'(yi_s1);
			end
			OP_MUL: begin
				sd.pre_r = mr >>> FRAC_BITS;
				sd.pre_i = mi >>> FRAC_BITS;
			end
			OP_DIV: begin
				sd.is_div = 1'b1;
			end
			OP_CONJ: begin
				sd.pre_r = PRE_W'(xr_s1);
				sd.pre_i = -PRE_W'(xi_s1);
			end
			default: begin
				sd.pre_r = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2  <= sd;
		neg_r_s2 <= nr[PRE_W-1];
		neg_i_s2 <= ni[PRE_W-1];
		num_r_s2 <= (NW'(mag_r) << (FRAC_BITS + 1)) + NW'(d);
		num_i_s2 <= (NW'(mag_i) << (FRAC_BITS + 1)) + NW'(d);
		den_s2   <= {1'b0, d} << 1;
	end

endmodule

@@ rtl/core/cau_div.sv @@
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, one quotient bit per stage. The top quotient
// bit marks a quotient of at least 2^(QB-1).
// ----------------------------------------------------------------------------
module cau_div #(
	parameter int NW = 42,
	parameter int SW = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  logic [NW-1:0]             num,
	input  logic [cau_pkg::DW-1:0]    den,
	input  logic [SW-1:0]             side_in,
	output logic                      out_vld,
	output logic [cau_pkg::QB-1:0]    quo,
	output logic [SW-1:0]             side_out
);
	import cau_pkg::*;

	localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

	logic [NW-1:0] rem_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic [SW-1:0] sd_s  [0:QB];
	logic          vld_s [0:QB];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign sd_s[0]  = side_in;
	assign vld_s[0] = in_vld;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [CW-1:0] sh;
		logic          ge;
		assign sh = CW'(den_s[k]) << (QB - 1 - k);
		assign ge = CW'(rem_s[k]) >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? NW'(CW'(rem_s[k]) - sh) : rem_s[k];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
			sd_s[k+1]  <= sd_s[k];
		end
	end

	assign out_vld  = vld_s[QB];
	assign quo      = quo_s[QB];
	assign side_out = sd_s[QB];

endmodule

@@ rtl/core/complex_arith_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply, divide and conjugate in signed fixed point
// with saturation and status.
//
//  channel  handshake      fields
//  in       start / busy   action, x_real, x_imag, y_real, y_imag
//  out      done           res_real, res_imag, status
//
// One word accepted per cycle; busy stays low. Every operation passes through
// the product stage, combine stage, 18 stage divider and output stage.
// Reset clears only the valid bits. Results cannot be held off.
// ----------------------------------------------------------------------------
module complex_arith_unit #(
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic signed [15:0] x_real,
	input  logic signed [15:0] x_imag,
	input  logic signed [15:0] y_real,
	input  logic signed [15:0] y_imag,
	output logic               done,
	output logic signed [15:0] res_real,
	output logic signed [15:0] res_imag,
	output logic [1:0]         status
);
	import cau_pkg::*;

	localparam int NW = FRAC_BITS + 34;
	localparam int SR = $bits(side_t) + 1;

	logic          f_vld, neg_r, neg_i;
	side_t         f_side;
	logic [NW-1:0] num_r, num_i;
	logic [DW-1:0] den;

	assign busy = 1'b0;

	cau_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
		.clk(clk), .arst_n(arst_n), .in_vld(start), .action(action),
		.x_real(x_real), .x_imag(x_imag), .y_real(y_real), .y_imag(y_imag),
		.vld_s2(f_vld), .side_s2(f_side), .neg_r_s2(neg_r), .neg_i_s2(neg_i),
		.num_r_s2(num_r), .num_i_s2(num_i), .den_s2(den)
	);

	logic          v_r, v_i;
	logic [QB-1:0] q_r, q_i;
	logic [SR-1:0] sd_r;
	logic          sd_i;

	cau_div #(.NW(NW), .SW(SR)) u_div_r (
		.clk(clk), .arst_n(arst_n), .in_vld(f_vld), .num(num_r), .den(den),
		.side_in({neg_r, f_side}), .out_vld(v_r), .quo(q_r), .side_out(sd_r)
	);

	cau_div #(.NW(NW), .SW(1)) u_div_i (
		.clk(clk), .arst_n(arst_n), .in_vld(f_vld), .num(num_i), .den(den),
		.side_in(neg_i), .out_vld(v_i), .quo(q_i), .side_out(sd_i)
	);

	side_t                   sd;
	logic                    nr_f;
	logic signed [PRE_W-1:0] qv_r, qv_i, val_r, val_i;
	sat_t                    sat_r, sat_i;
	logic [1:0]              st;

	always_comb begin
		{nr_f, sd} = sd_r;
		qv_r  = PRE_W'(q_r);
		qv_i  = PRE_W'(q_i);
		val_r = sd.pre_r;
		val_i = sd.pre_i;
		if (sd.is_div) begin
			if (sd.divz) begin
				val_r = '0;
				val_i = '0;
			end else begin
				val_r = nr_f ? -qv_r : qv_r;
				val_i = sd_i ? -qv_i : qv_i;
			end
		end
		sat_r = sat16(val_r);
		sat_i = sat16(val_i);
		if (sd.is_div && sd.divz) begin
			st = ST_DIVZERO;
		end else if (sat_r.ovf || sat_i.ovf) begin
			st = ST_OVF;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_r & v_i;
		end
	end

	always_ff @(posedge clk) begin
		res_real <= sat_r.val;
		res_imag <= sat_i.val;
		status   <= st;
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##21 done) else $error("result strobe missing");
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		v_r == v_i) else $error("divider lanes out of step");
	a_divz: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_DIVZERO |-> res_real == 16'sd0 && res_imag == 16'sd0)
		else $error("divide by zero result not zero");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3) else $error("bad status code");
`endif

endmodule

@@ tb/tb_complex_arith_unit.sv @@
// ----------------------------------------------------------------------------
// tb_complex_arith_unit
// Self-checking bench for the complex arithmetic unit. A directed set of
// corner words and 400 random words go through a queue to a clocked
// driver; a clocked monitor compares every done word against a predictor
// in the bench, under several sender idle phases and one drain pause.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit;
	import cau_pkg::*;

	localparam int FB      = 8;
	localparam int LATENCY = 21;
	localparam int WDOG    = 2000;

	typedef struct {
		logic [2:0]         act;
		logic signed [15:0] xr, xi, yr, yi;
	} cmd_t;

	typedef struct {
		logic signed [15:0] rr, ri;
		logic [1:0]         st;
	} cres_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] action = '0;
	logic signed [15:0] x_real = '0, x_imag = '0, y_real = '0, y_imag = '0;
	logic done;
	logic signed [15:0] res_real, res_imag;
	logic [1:0] status;

	cmd_t  pending_q[$];
	cres_t expected_q[$];
	int    idle_pct = 0;
	bit    hold = 1'b0;
	int    n_err = 0;
	int    n_words = 0;
	int    n_div = 0, n_ovf = 0, n_divz = 0;
	int    quiet = 0;

	complex_arith_unit #(.FRAC_BITS(FB)) dut (.*);

	always #6 clk = ~clk;

	function automatic longint rnd_prod(longint p);
		return (p + (longint'(1) << (FB - 1))) >>> FB;
	endfunction

	function automatic longint rnd_quot(longint n, longint d);
		longint m, q;
		m = (n < 0) ? -n : n;
		q = ((m << (FB + 1)) + d) / (d << 1);
		return (n < 0) ? -q : q;
	endfunction

	function automatic logic signed [15:0] clip(longint v, inout bit ovf);
		if (v > 32767) begin
			ovf = 1'b1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			ovf = 1'b1;
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic cres_t complex_result(cmd_t c);
		cres_t r;
		longint xr, xi, yr, yi, a, b, d;
		bit ovf;
		xr = c.xr; xi = c.xi; yr = c.yr; yi = c.yi;
		a = 0; b = 0; ovf = 1'b0;
		r.st = ST_OK;
		case (c.act)
			OP_ADD: begin a = xr + yr; b = xi + yi; end
			OP_SUB: begin a = xr - yr; b = xi - yi; end
			OP_MUL: begin
				a = rnd_prod(xr * yr - xi * yi);
				b = rnd_prod(xr * yi + xi * yr);
			end
			OP_DIV: begin
				d = yr * yr + yi * yi;
				if (d == 0) r.st = ST_DIVZERO;
				else begin
					a = rnd_quot(xr * yr + xi * yi, d);
					b = rnd_quot(xi * yr - xr * yi, d);
				end
			end
			OP_CONJ: begin a = xr; b = -xi; end
			default: ;
		endcase
		r.rr = clip(a, ovf);
		r.ri = clip(b, ovf);
		if (ovf && r.st == ST_OK) r.st = ST_OVF;
		return r;
	endfunction

	function automatic logic signed [15:0] rnd_part();
		case ($urandom_range(0, 5))
			0: return 16'(int'($urandom_range(0, 4)) - 2);
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2: return 16'($urandom_range(0, 2047)) - 16'sd1024;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push(logic [2:0] a, logic signed [15:0] xr, xi, yr, yi);
		cmd_t c;
		c.act = a; c.xr = xr; c.xi = xi; c.yr = yr; c.yi = yi;
		pending_q.push_back(c);
	endtask

	task automatic push_random(int n);
		cmd_t c;
		repeat (n) begin
			c.act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(OP_ADD, OP_CONJ));
			c.xr = rnd_part(); c.xi = rnd_part();
			c.yr = rnd_part(); c.yi = rnd_part();
			if (c.act == OP_DIV && $urandom_range(0, 9) == 0) begin
				c.yr = '0; c.yi = '0;
			end
			pending_q.push_back(c);
		end
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0 || expected_q.size() != 0 || start)
			@(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		cmd_t c;
		if (arst_n) begin
			if (start && !busy) begin
				c.act = action; c.xr = x_real; c.xi = x_imag;
				c.yr = y_real; c.yi = y_imag;
				expected_q.push_back(complex_result(c));
				n_words <= n_words + 1;
				if (c.act == OP_DIV) n_div <= n_div + 1;
			end
			if ((!start || !busy) && pending_q.size() != 0 && !hold
					&& $urandom_range(1, 100) > idle_pct) begin
				c = pending_q.pop_front();
				start  <= 1'b1;
				action <= c.act;
				x_real <= c.xr; x_imag <= c.xi;
				y_real <= c.yr; y_imag <= c.yi;
			end else if (!start || !busy) begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cres_t e;
		if (arst_n) begin
			quiet <= (done || (start && !busy)) ? 0 : quiet + 1;
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result word %0d %0d %0d",
						res_real, res_imag, status);
					n_err++;
				end else begin
					e = expected_q.pop_front();
					if (status == ST_OVF) n_ovf <= n_ovf + 1;
					if (status == ST_DIVZERO) n_divz <= n_divz + 1;
					if (res_real !== e.rr) begin
						$error("res_real: expected %0d, got %0d", e.rr, res_real);
						n_err++;
					end
					if (res_imag !== e.ri) begin
						$error("res_imag: expected %0d, got %0d", e.ri, res_imag);
						n_err++;
					end
					if (status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, status);
						n_err++;
					end
				end
			end
			if (quiet >= WDOG) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		push(OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		push(OP_ADD, 16'sh0100, -16'sh0100, 16'sh0080, 16'sh0040);
		push(OP_SUB, 16'sh8000, 16'sh7fff, 16'sh0001, -16'sd1);
		push(OP_SUB, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh7fff);
		push(OP_MUL, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000);
		push(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		push(OP_MUL, 16'sh0001, 16'sh0000, 16'sh0080, 16'sh0000);
		push(OP_MUL, -16'sd1, 16'sh0000, 16'sh0080, 16'sh0000);
		push(OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
		push(OP_DIV, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000);
		push(OP_DIV, 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000);
		push(OP_DIV, 16'sh0100, 16'sh0100, 16'sh0100, -16'sh0100);
		push(OP_DIV, 16'sh7fff, 16'sh8000, 16'sh0001, 16'sh0000);
		push(OP_DIV, 16'sh0001, -16'sd1, 16'sh7fff, 16'sh8000);
		push(OP_DIV, -16'sd3, 16'sh0005, 16'sh0300, 16'sh0000);
		push(OP_CONJ, 16'sh1234, 16'sh8000, 16'sh0000, 16'sh0000);
		push(OP_CONJ, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		push(OP_CONJ, -16'sd1, 16'sh0000, -16'sd1, -16'sd1);
		push(3'd5, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		push(3'd6, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		push(3'd7, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
		wait_drained();

		idle_pct = 0;  push_random(100); wait_drained();
		idle_pct = 76; push_random(100); wait_drained();
		hold = 1'b1;
		repeat (LATENCY + 5) @(posedge clk);
		hold = 1'b0;
		idle_pct = 38; push_random(100); wait_drained();
		idle_pct = 0;  push_random(100); wait_drained();

		repeat (LATENCY + 5) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d result words never arrived", expected_q.size());
			n_err++;
		end
		$display("Covered %0d words (%0d divides): %0d saturated, %0d zero divisors.",
			n_words, n_div, n_ovf, n_divz);
		if (n_err == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_div.sv
rtl/core/complex_arith_unit.sv
tb/tb_complex_arith_unit.sv
